[design/plc_pkg.sv]
// Shared constants, codes and command type for the positional list store.
`default_nettype none
package plc_pkg;

  localparam int Capacity = 64;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int IdxW     = $clog2(Capacity);
  localparam int PosW     = 8;
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;
  localparam int DataW    = 32;
  localparam int LenW     = 7;

  localparam logic [2:0] FuncInsAt  = 3'd0;
  localparam logic [2:0] FuncAppend = 3'd1;
  localparam logic [2:0] FuncDelAt  = 3'd2;
  localparam logic [2:0] FuncDelEnd = 3'd3;
  localparam logic [2:0] FuncRdAt   = 3'd4;
  localparam logic [2:0] FuncRdEnd  = 3'd5;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadPos = 2'd1;
  localparam logic [1:0] StEmpty  = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [CmpW-1:0]  pos;
    logic [DataW-1:0] value;
  } plc_cmd_t;

endpackage
`default_nettype wire

[design/positional_list_store_top.sv]
// Top level of the positional list store: control, row of entry cells and result register.
// A request accepted at one edge shows its result, with done_o high, in the next cycle.
// Throughput: one request per cycle; busy stays low, since the whole row of cells
// shifts in the same edge that accepts an insert or delete.
// Reset clears the length to zero and drops any pending result; entry contents are
// undefined until written. The receiver cannot stall results.
`default_nettype none
module positional_list_store_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               func_i,
  input  wire logic [plc_pkg::PosW-1:0] position_i,
  input  wire logic signed [31:0]       value_i,
  output logic                          done_o,
  output logic signed [31:0]            read_value_o,
  output logic [6:0]                    list_length_o,
  output logic [1:0]                    status_o
);
  import plc_pkg::*;

  plc_cmd_t        cmd;
  logic [1:0]      status;
  logic [CntW-1:0] count_nxt;
  logic            req;

  logic [DataW-1:0] cell_data [Capacity];
  logic [DataW-1:0] cell_rd   [Capacity];
  logic [DataW-1:0] rd_any;

  logic             done_q;
  logic [DataW-1:0] rdv_q;
  logic [LenW-1:0]  len_q;
  logic [1:0]       st_q;

  assign busy = 1'b0;
  assign req  = start && !busy;

  plc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .func_i     (func_i),
    .position_i (position_i),
    .value_i    (DataW'(value_i)),
    .cmd_o      (cmd),
    .status_o   (status),
    .count_o    (count_nxt)
  );

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] prev_w;
    logic [DataW-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end
    plc_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IdxW'(i)),
      .cmd_i  (cmd),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < Capacity; k++) begin
      rd_any = rd_any | cell_rd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      rdv_q <= rd_any;
      len_q <= LenW'(count_nxt);
      st_q  <= status;
    end
  end

  assign done_o        = done_q;
  assign read_value_o  = signed'(rdv_q);
  assign list_length_o = len_q;
  assign status_o      = st_q;

endmodule
`default_nettype wire

[design/plc_cell.sv]
// One list entry: takes the new value or a neighbor's entry, and drives its entry on a read hit.
`default_nettype none
module plc_cell (
  input  wire logic                    clk_i,
  input  wire logic [plc_pkg::IdxW-1:0] idx_i,
  input  wire plc_pkg::plc_cmd_t       cmd_i,
  input  wire logic [plc_pkg::DataW-1:0] prev_i,
  input  wire logic [plc_pkg::DataW-1:0] next_i,
  output logic [plc_pkg::DataW-1:0]    data_o,
  output logic [plc_pkg::DataW-1:0]    rd_o
);
  import plc_pkg::*;

  logic [DataW-1:0] entry_q;
  logic [DataW-1:0] entry_d;
  logic [CmpW-1:0]  idx_ext;

  assign idx_ext = CmpW'(idx_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (idx_ext > cmd_i.pos) begin
        entry_d = prev_i;
      end else if (idx_ext == cmd_i.pos) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del && (idx_ext >= cmd_i.pos)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;
  assign rd_o   = (cmd_i.rd && (idx_ext == cmd_i.pos)) ? entry_q : '0;

endmodule
`default_nettype wire

[design/plc_ctrl.sv]
// Request decode, range checks and entry count for the positional list store.
`default_nettype none
module plc_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_i,
  input  wire logic [2:0]              func_i,
  input  wire logic [plc_pkg::PosW-1:0] position_i,
  input  wire logic [plc_pkg::DataW-1:0] value_i,
  output plc_pkg::plc_cmd_t            cmd_o,
  output logic [1:0]                   status_o,
  output logic [plc_pkg::CntW-1:0]     count_o
);
  import plc_pkg::*;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [CmpW-1:0] count_ext;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] tgt_pos;
  logic            full;

  assign count_ext = CmpW'(count_q);
  assign pos_ext   = CmpW'(position_i);
  assign full      = (count_q == CntW'(Capacity));

  always_comb begin
    cmd_o       = '0;
    cmd_o.value = value_i;
    status_o    = StOk;
    tgt_pos     = pos_ext;
    case (func_i)
      FuncInsAt, FuncAppend: begin
        if (func_i == FuncAppend) begin
          tgt_pos = count_ext;
        end
        if (full) begin
          status_o = StFull;
        end else if (tgt_pos > count_ext) begin
          status_o = StBadPos;
        end else begin
          cmd_o.ins = req_i;
        end
      end
      FuncDelAt, FuncDelEnd, FuncRdAt, FuncRdEnd: begin
        if ((func_i == FuncDelEnd) || (func_i == FuncRdEnd)) begin
          tgt_pos = count_ext - CmpW'(1);
        end
        if (count_q == '0) begin
          status_o = StEmpty;
        end else if (tgt_pos >= count_ext) begin
          status_o = StBadPos;
        end else if ((func_i == FuncDelAt) || (func_i == FuncDelEnd)) begin
          cmd_o.del = req_i;
        end else begin
          cmd_o.rd = req_i;
        end
      end
      default: begin
        status_o = StOk;
      end
    endcase
    cmd_o.pos = tgt_pos;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_o.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_o.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity)) else $error("count exceeds capacity");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ins && cmd_o.del) && !(cmd_o.ins && cmd_o.rd) && !(cmd_o.del && cmd_o.rd))
    else $error("more than one list operation at once");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |=> count_q == CntW'($past(count_q) + CntW'(1)))
    else $error("insert did not grow the list");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i && (status_o == StFull)) |=> count_q == CntW'(Capacity))
    else $error("full list changed length");

endmodule
`default_nettype wire
